// ===== design/buzzer_melody_sequencer_unit_defines.svh =====
// Assertion macros for the buzzer melody sequencer top level.
`ifndef BUZZER_MELODY_SEQUENCER_UNIT_DEFINES_SVH
`define BUZZER_MELODY_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bms_pkg.sv =====
// Package with types, constants and the control store of the melody sequencer.
package bms_pkg;

	localparam int NOTE_DEPTH_DEF = 256;
	localparam logic [7:0] END_MARK = 8'hff;
	localparam logic [15:0] UNIT_TICKS_RESET = 16'd1875;
	localparam logic [15:0] GAP_TICKS_RESET = 16'd625;

	localparam logic REG_UNIT_TICKS = 1'b0;
	localparam logic REG_GAP_TICKS = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_WRITE = 2'd1,
		OP_PLAY = 2'd2,
		OP_STOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_NOTE = 2'd1,
		PH_GAP = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		A_NONE,
		A_NOTE_TICK,
		A_GAP_TICK,
		A_READ_DIV,
		A_LOAD_DIV,
		A_LOAD_LEN,
		A_END,
		A_WRITE,
		A_PLAY,
		A_EMIT
	} act_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_PH_NOTE,
		C_PH_GAP,
		C_GAP_DONE,
		C_RD_END
	} cond_t;

	typedef logic [3:0] upc_t;

	localparam upc_t S_IDLE = 4'd0;
	localparam upc_t S_TICK = 4'd1;
	localparam upc_t S_TICK2 = 4'd2;
	localparam upc_t S_NOTE = 4'd3;
	localparam upc_t S_GAP = 4'd4;
	localparam upc_t S_FETCH = 4'd5;
	localparam upc_t S_DIV = 4'd6;
	localparam upc_t S_LEN = 4'd7;
	localparam upc_t S_END = 4'd8;
	localparam upc_t S_WRITE = 4'd9;
	localparam upc_t S_PLAY = 4'd10;
	localparam upc_t S_EMIT = 4'd11;

	typedef struct packed {
		act_t act;
		cond_t cond;
		upc_t target;
		upc_t alt;
	} ctrl_t;

	typedef struct packed {
		logic ph_note;
		logic ph_gap;
		logic gap_done;
		logic rd_end;
	} stat_t;

	function automatic ctrl_t ucode(input upc_t upc);
		ctrl_t w;
		case (upc)
			S_IDLE: w = '{A_NONE, C_ALWAYS, S_IDLE, S_IDLE};
			S_TICK: w = '{A_NONE, C_PH_NOTE, S_NOTE, S_TICK2};
			S_TICK2: w = '{A_NONE, C_PH_GAP, S_GAP, S_EMIT};
			S_NOTE: w = '{A_NOTE_TICK, C_ALWAYS, S_EMIT, S_EMIT};
			S_GAP: w = '{A_GAP_TICK, C_GAP_DONE, S_FETCH, S_EMIT};
			S_FETCH: w = '{A_READ_DIV, C_ALWAYS, S_DIV, S_DIV};
			S_DIV: w = '{A_LOAD_DIV, C_RD_END, S_END, S_LEN};
			S_LEN: w = '{A_LOAD_LEN, C_ALWAYS, S_EMIT, S_EMIT};
			S_END: w = '{A_END, C_ALWAYS, S_EMIT, S_EMIT};
			S_WRITE: w = '{A_WRITE, C_ALWAYS, S_EMIT, S_EMIT};
			S_PLAY: w = '{A_PLAY, C_ALWAYS, S_FETCH, S_FETCH};
			S_EMIT: w = '{A_EMIT, C_ALWAYS, S_IDLE, S_IDLE};
			default: w = '{A_NONE, C_ALWAYS, S_IDLE, S_IDLE};
		endcase
		return w;
	endfunction

	function automatic upc_t entry_step(input op_t op);
		upc_t s;
		case (op)
			OP_TICK: s = S_TICK;
			OP_WRITE: s = S_WRITE;
			OP_PLAY: s = S_PLAY;
			OP_STOP: s = S_END;
			default: s = S_END;
		endcase
		return s;
	endfunction

endpackage

// ===== design/bms_sequencer.sv =====
// Step counter and control store that steer the melody datapath.
module bms_sequencer
	import bms_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [1:0] operation,
	input stat_t stat,
	output ctrl_t ctrl,
	output logic busy
);

	upc_t pc_q;
	upc_t pc_next;
	logic cond_true;

	assign ctrl = ucode(pc_q);
	assign busy = (pc_q != S_IDLE);

	always_comb begin
		case (ctrl.cond)
			C_ALWAYS: cond_true = 1'b1;
			C_PH_NOTE: cond_true = stat.ph_note;
			C_PH_GAP: cond_true = stat.ph_gap;
			C_GAP_DONE: cond_true = stat.gap_done;
			C_RD_END: cond_true = stat.rd_end;
			default: cond_true = 1'b1;
		endcase
	end

	always_comb begin
		if (!busy) begin
			pc_next = start ? entry_step(op_t'(operation)) : S_IDLE;
		end else begin
			pc_next = cond_true ? ctrl.target : ctrl.alt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

// ===== design/buzzer_melody_sequencer_unit.sv =====
// Top level of the buzzer melody sequencer: registers, note memory and datapath.
// Usage:
// An item is taken at a rising edge with start high and busy low; operation picks
// tick, note memory write, play from address, or stop, with address and data.
// Every item gives exactly one result beat: result_valid is high for one cycle
// with speaker_level, playing and done_res; the receiver cannot hold it off.
// Steps to the result beat: write S_WRITE; stop S_END; tick S_TICK, then S_NOTE
// in a note, S_TICK2 while idle, or S_TICK2, S_GAP in a gap and, as the gap ends,
// S_FETCH, S_DIV, S_LEN or S_END; play S_PLAY, S_FETCH, S_DIV, S_LEN or S_END;
// all end in S_EMIT. Fetch: two registered note memory reads, divider then length.
// busy is high from acceptance until the result beat, so items are handled one at
// a time; the next item can be taken in the cycle of the result beat.
// unit_ticks and gap_ticks are written through the APB port at byte offsets
// 0 and 4; a read returns the value. Reset clears the player to idle with the pin
// low and loads unit_ticks 1875 and gap_ticks 625; the note memory is not
// cleared and holds whatever was written.
`include "buzzer_melody_sequencer_unit_defines.svh"

module buzzer_melody_sequencer_unit
	import bms_pkg::*;
#(
	parameter int NOTE_DEPTH = NOTE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic start,
	output logic busy,
	input logic [1:0] operation,
	input logic [7:0] address,
	input logic [7:0] data,
	output logic result_valid,
	output logic speaker_level,
	output logic playing,
	output logic done_res
);

	localparam int AW = $clog2(NOTE_DEPTH);

	logic [15:0] unit_ticks_q;
	logic [15:0] gap_ticks_q;
	logic [7:0] addr_q;
	logic [7:0] data_q;
	logic [7:0] read_pointer_q;
	logic [7:0] divider_q;
	logic [7:0] divider_count_q;
	logic [7:0] units_left_q;
	logic [15:0] tick_count_q;
	phase_t phase_q;
	logic pin_q;
	logic done_q;
	logic result_valid_q;
	logic speaker_level_q;
	logic playing_q;
	logic done_res_q;
	logic [7:0] note_mem [NOTE_DEPTH];
	logic [7:0] rd_q;
	logic [7:0] rd_ptr;
	logic [16:0] tick_inc;
	logic [7:0] units_dec;
	logic cfg_wr;
	logic accept;
	ctrl_t ctrl;
	stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign accept = start & ~busy;

	always_comb begin
		case (paddr[2])
			REG_UNIT_TICKS: prdata = {16'd0, unit_ticks_q};
			REG_GAP_TICKS: prdata = {16'd0, gap_ticks_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
			gap_ticks_q <= GAP_TICKS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_UNIT_TICKS) begin
				unit_ticks_q <= pwdata[15:0];
			end else begin
				gap_ticks_q <= pwdata[15:0];
			end
		end
	end

	bms_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.operation(operation),
		.stat(stat),
		.ctrl(ctrl),
		.busy(busy)
	);

	assign tick_inc = {1'b0, tick_count_q} + 17'd1;
	assign units_dec = units_left_q - 8'd1;

	always_comb begin
		stat.ph_note = (phase_q == PH_NOTE);
		stat.ph_gap = (phase_q == PH_GAP);
		stat.gap_done = (tick_inc >= {1'b0, gap_ticks_q});
		stat.rd_end = (rd_q == END_MARK);
	end

	assign rd_ptr = (ctrl.act == A_LOAD_DIV) ? (read_pointer_q + 8'd1) : read_pointer_q;

	always_ff @(posedge clk) begin
		rd_q <= note_mem[rd_ptr[AW-1:0]];
		if (ctrl.act == A_WRITE) begin
			note_mem[addr_q[AW-1:0]] <= data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= address;
			data_q <= data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_pointer_q <= 8'd0;
			divider_q <= 8'd0;
			divider_count_q <= 8'd0;
			units_left_q <= 8'd0;
			tick_count_q <= 16'd0;
			phase_q <= PH_IDLE;
			pin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (accept) begin
				done_q <= 1'b0;
			end
			case (ctrl.act)
				A_NOTE_TICK: begin
					if (divider_q == 8'd0) begin
						divider_count_q <= 8'd0;
					end else if (divider_count_q >= divider_q) begin
						pin_q <= ~pin_q;
						divider_count_q <= 8'd0;
					end else begin
						divider_count_q <= divider_count_q + 8'd1;
					end
					if (tick_inc >= {1'b0, unit_ticks_q}) begin
						tick_count_q <= 16'd0;
						units_left_q <= units_dec;
						if (units_dec == 8'd0) begin
							divider_q <= 8'd0;
							phase_q <= PH_GAP;
						end
					end else begin
						tick_count_q <= tick_inc[15:0];
					end
				end
				A_GAP_TICK: begin
					divider_count_q <= 8'd0;
					tick_count_q <= tick_inc[15:0];
				end
				A_LOAD_DIV: begin
					divider_q <= rd_q;
				end
				A_LOAD_LEN: begin
					units_left_q <= rd_q;
					read_pointer_q <= read_pointer_q + 8'd2;
					tick_count_q <= 16'd0;
					if (rd_q == 8'd0) begin
						divider_q <= 8'd0;
						phase_q <= PH_GAP;
					end else begin
						phase_q <= PH_NOTE;
					end
				end
				A_END: begin
					pin_q <= 1'b0;
					divider_q <= 8'd0;
					divider_count_q <= 8'd0;
					units_left_q <= 8'd0;
					tick_count_q <= 16'd0;
					phase_q <= PH_IDLE;
					done_q <= 1'b1;
				end
				A_PLAY: begin
					read_pointer_q <= addr_q;
					pin_q <= 1'b0;
					divider_count_q <= 8'd0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (ctrl.act == A_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.act == A_EMIT) begin
			speaker_level_q <= pin_q;
			playing_q <= (phase_q != PH_IDLE);
			done_res_q <= done_q;
		end
	end

	assign result_valid = result_valid_q;
	assign speaker_level = speaker_level_q;
	assign playing = playing_q;
	assign done_res = done_res_q;

	`BMS_ASSERT_NEXT(a_accept_busy, accept, busy, "Accepted item did not make the block busy.")
	`BMS_ASSERT_NEXT(a_one_beat, result_valid, !result_valid, "Result beat lasted more than one cycle.")
	`BMS_ASSERT_NOW(a_idle_pin_low, phase_q == PH_IDLE, !pin_q, "Speaker pin high while idle.")
	`BMS_ASSERT_NOW(a_note_units, phase_q == PH_NOTE, units_left_q != 8'd0, "Note phase with no units left.")
	`BMS_ASSERT_NOW(a_done_idle, result_valid && done_res, !playing, "Done beat reported a tune still playing.")

endmodule
